// ===== design/tle_pkg.sv =====
`timescale 1ns / 1ps
// Package of the tier latency estimator: payload structs, controller states,
// register map and reset constants. Depends on nothing.
package tle_pkg;

  localparam int DATA_W = 64;
  localparam int SHIFT_W = 4;
  localparam int MIN_W = 16;
  localparam int HIST_W = (1 << SHIFT_W) - 1;
  localparam int CNT_W = $clog2(DATA_W);
  localparam int LANES = 4;
  localparam int TIERS = 2;
  localparam int FRACTION_BITS_DEF = 10;

  localparam int ADDR_W = 4;
  localparam int PDATA_W = 32;

  // Register map, word index within the APB window
  localparam logic [1:0] REG_EWMA_SHIFT = 2'd0;
  localparam logic [1:0] REG_MIN_LOCAL = 2'd1;
  localparam logic [1:0] REG_MIN_REMOTE = 2'd2;

  localparam logic [SHIFT_W-1:0] SHIFT_RESET = 4'd5;
  localparam logic [MIN_W-1:0] MIN_LOCAL_RESET = 16'd100;
  localparam logic [MIN_W-1:0] MIN_REMOTE_RESET = 16'd300;

  typedef struct packed {
    logic [DATA_W-1:0] local_occupancy_count;
    logic [DATA_W-1:0] local_insert_count;
    logic [DATA_W-1:0] remote_occupancy_count;
    logic [DATA_W-1:0] remote_insert_count;
  } in_data_t;

  typedef struct packed {
    logic [DATA_W-1:0] local_latency;
    logic [DATA_W-1:0] remote_latency;
    logic              local_slower;
    logic              primed_only;
  } out_data_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EWMA,
    ST_ALIGN,
    ST_DLOAD,
    ST_DIVIDE,
    ST_CLAMP,
    ST_EMIT
  } state_t;

endpackage

// ===== design/tier_latency_estimator.sv =====
`timescale 1ns / 1ps
// Top level of the tier latency estimator: bit-serial delta and moving
// average lanes, a radix-2 divider per tier and the APB register file.
// Depends on tle_pkg.
//
//  channel | direction | handshake              | payload
//  in_     | in        | in_valid / in_ready    | in_data   (in_data_t)
//  out_    | out       | out_valid / out_ready  | out_data  (out_data_t)
//  cfg     | in/out    | psel penable pwrite    | paddr pwdata prdata pready
//
// A request after the priming one runs from acceptance to result through a
// bit-serial pass over all 64 bits of the four average lanes, a final right
// shift by ewma_shift, one divider load, the divider steps, one clamp step
// and one output step. The priming request goes straight to the output step.
// The block goes idle after each result, before it accepts the next request.
// One request is in flight at a time; in_ready is high only when idle.
// A result held in the output register stalls only the output stage.
// rst_n is synchronous; it restores register defaults and clears the averages.
module tier_latency_estimator
  import tle_pkg::*;
#(
  parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  in_data_t           in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output out_data_t          out_data,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [ADDR_W-1:0]  paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready
);

  localparam int DW = FRACTION_BITS + 1;

  // Control state
  state_t             state_r, state_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic               primed_r;
  logic               out_valid_r;
  out_data_t          out_data_r;

  // Configuration
  logic [SHIFT_W-1:0] shift_r;
  logic [MIN_W-1:0]   min_local_r;
  logic [MIN_W-1:0]   min_remote_r;

  // Serial lanes
  logic [LANES-1:0][DATA_W-1:0] in_sr_r;
  logic [LANES-1:0][DATA_W-1:0] prev_r;
  logic [LANES-1:0][DATA_W-1:0] sum_r;
  logic [LANES-1:0][DW-1:0]     dchain_r;
  logic [LANES-1:0][HIST_W-1:0] hist_r;
  logic [LANES-1:0]             bdiff_r;
  logic [LANES-1:0]             carry_r;
  logic [LANES-1:0]             bsum_r;

  logic [LANES-1:0][DW:0]       dvec;
  logic [LANES-1:0][HIST_W:0]   hvec;
  logic [LANES-1:0]             diff_b, d_b, ssh_b, u_b, t_b;

  // Dividers
  logic [TIERS-1:0][DATA_W-1:0] dq_r, drem_r, ddiv_r;
  logic [TIERS-1:0][DATA_W:0]   rs, dsub;
  logic [TIERS-1:0]             ge;

  // Clamped latencies
  logic [DATA_W-1:0]  lat_local_r, lat_remote_r, lat_local_c, lat_remote_c;
  logic               po_r;

  // Controller strobes
  logic in_acc, cfg_wr, last64, align_last, emit_en;
  logic lane_run, lane_align, div_load, div_run, clamp_en;

  assign in_acc     = in_valid && in_ready;
  assign cfg_wr     = psel && penable && pwrite;
  assign last64     = (cnt_r == CNT_W'(DATA_W - 1));
  assign align_last = (cnt_r[SHIFT_W-1:0] == shift_r - 1'b1);

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_acc) state_nxt = primed_r ? ST_EWMA : ST_EMIT;
      end
      ST_EWMA: begin
        if (last64) state_nxt = (shift_r == '0) ? ST_DLOAD : ST_ALIGN;
      end
      ST_ALIGN: begin
        if (align_last) state_nxt = ST_DLOAD;
      end
      ST_DLOAD:  state_nxt = ST_DIVIDE;
      ST_DIVIDE: begin
        if (last64) state_nxt = ST_CLAMP;
      end
      ST_CLAMP:  state_nxt = ST_EMIT;
      ST_EMIT: begin
        if (!out_valid_r || out_ready) state_nxt = ST_IDLE;
      end
      default:   state_nxt = ST_IDLE;
    endcase
  end

  // Controller outputs
  always_comb begin
    in_ready   = 1'b0;
    lane_run   = 1'b0;
    lane_align = 1'b0;
    div_load   = 1'b0;
    div_run    = 1'b0;
    clamp_en   = 1'b0;
    emit_en    = 1'b0;
    case (state_r)
      ST_IDLE:   in_ready = 1'b1;
      ST_EWMA:   lane_run = 1'b1;
      ST_ALIGN:  lane_align = 1'b1;
      ST_DLOAD:  div_load = 1'b1;
      ST_DIVIDE: div_run = 1'b1;
      ST_CLAMP:  clamp_en = 1'b1;
      ST_EMIT:   emit_en = !out_valid_r || out_ready;
      default:   in_ready = 1'b0;
    endcase
  end

  // Step counter restarts on every state change
  assign cnt_nxt = (state_nxt != state_r) ? '0 : cnt_r + 1'b1;

  // One bit per lane per cycle: delta, shifted delta, average term
  always_comb begin
    for (int i = 0; i < LANES; i++) begin
      diff_b[i] = in_sr_r[i][0] ^ prev_r[i][0] ^ bdiff_r[i];
      dvec[i]   = {dchain_r[i], diff_b[i]};
      d_b[i]    = dvec[i][FRACTION_BITS];
      hvec[i]   = {hist_r[i], sum_r[i][0]};
      ssh_b[i]  = hvec[i][shift_r];
      u_b[i]    = d_b[i] ^ ssh_b[i] ^ carry_r[i];
      t_b[i]    = u_b[i] ^ sum_r[i][0] ^ bsum_r[i];
    end
  end

  // One restoring step per tier
  always_comb begin
    for (int j = 0; j < TIERS; j++) begin
      rs[j]   = {drem_r[j], dq_r[j][DATA_W-1]};
      dsub[j] = rs[j] - {1'b0, ddiv_r[j]};
      ge[j]   = !dsub[j][DATA_W];
    end
  end

  // Fall back to the floor on zero inserts or a quotient below it
  always_comb begin
    lat_local_c  = DATA_W'(min_local_r);
    lat_remote_c = DATA_W'(min_remote_r);
    if (ddiv_r[0] != '0 && dq_r[0] > DATA_W'(min_local_r)) lat_local_c = dq_r[0];
    if (ddiv_r[1] != '0 && dq_r[1] > DATA_W'(min_remote_r)) lat_remote_c = dq_r[1];
  end

  // Control and architectural state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      cnt_r        <= '0;
      primed_r     <= 1'b0;
      out_valid_r  <= 1'b0;
      shift_r      <= SHIFT_RESET;
      min_local_r  <= MIN_LOCAL_RESET;
      min_remote_r <= MIN_REMOTE_RESET;
      sum_r        <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      if (in_acc) primed_r <= 1'b1;
      // Drop a taken result, hold a new one
      if (emit_en) out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
      if (cfg_wr) begin
        case (paddr[3:2])
          REG_EWMA_SHIFT: shift_r <= pwdata[SHIFT_W-1:0];
          REG_MIN_LOCAL:  min_local_r <= pwdata[MIN_W-1:0];
          REG_MIN_REMOTE: min_remote_r <= pwdata[MIN_W-1:0];
          default:        shift_r <= shift_r;
        endcase
      end
      // Push new average bits in at the top, then shift right by ewma_shift
      for (int i = 0; i < LANES; i++) begin
        if (lane_run) sum_r[i] <= {t_b[i], sum_r[i][DATA_W-1:1]};
        else if (lane_align) sum_r[i] <= {1'b0, sum_r[i][DATA_W-1:1]};
      end
    end
  end

  // Datapath without reset
  always_ff @(posedge clk) begin
    if (in_acc) begin
      if (!primed_r) begin
        prev_r[0]    <= in_data.local_occupancy_count;
        prev_r[1]    <= in_data.local_insert_count;
        prev_r[2]    <= in_data.remote_occupancy_count;
        prev_r[3]    <= in_data.remote_insert_count;
        lat_local_r  <= DATA_W'(min_local_r);
        lat_remote_r <= DATA_W'(min_remote_r);
      end
      in_sr_r[0] <= in_data.local_occupancy_count;
      in_sr_r[1] <= in_data.local_insert_count;
      in_sr_r[2] <= in_data.remote_occupancy_count;
      in_sr_r[3] <= in_data.remote_insert_count;
      dchain_r   <= '0;
      hist_r     <= '0;
      bdiff_r    <= '0;
      carry_r    <= '0;
      bsum_r     <= '0;
      po_r       <= !primed_r;
    end
    // Advance the serial lanes one bit
    if (lane_run) begin
      for (int i = 0; i < LANES; i++) begin
        in_sr_r[i]  <= {1'b0, in_sr_r[i][DATA_W-1:1]};
        prev_r[i]   <= {in_sr_r[i][0], prev_r[i][DATA_W-1:1]};
        dchain_r[i] <= dvec[i][DW-1:0];
        hist_r[i]   <= hvec[i][HIST_W-1:0];
        bdiff_r[i]  <= (!in_sr_r[i][0] && prev_r[i][0]) ||
                       (!(in_sr_r[i][0] ^ prev_r[i][0]) && bdiff_r[i]);
        carry_r[i]  <= (d_b[i] && ssh_b[i]) || (d_b[i] && carry_r[i]) ||
                       (ssh_b[i] && carry_r[i]);
        bsum_r[i]   <= (!u_b[i] && sum_r[i][0]) ||
                       (!(u_b[i] ^ sum_r[i][0]) && bsum_r[i]);
      end
    end
    // Load and step the dividers
    for (int j = 0; j < TIERS; j++) begin
      if (div_load) begin
        dq_r[j]   <= sum_r[2*j];
        ddiv_r[j] <= sum_r[2*j+1];
        drem_r[j] <= '0;
      end else if (div_run) begin
        dq_r[j]   <= {dq_r[j][DATA_W-2:0], ge[j]};
        drem_r[j] <= ge[j] ? dsub[j][DATA_W-1:0] : rs[j][DATA_W-1:0];
      end
    end
    if (clamp_en) begin
      lat_local_r  <= lat_local_c;
      lat_remote_r <= lat_remote_c;
    end
    if (emit_en) begin
      out_data_r.local_latency  <= lat_local_r;
      out_data_r.remote_latency <= lat_remote_r;
      out_data_r.local_slower   <= (lat_local_r > lat_remote_r);
      out_data_r.primed_only    <= po_r;
    end
  end

  // Register read-back
  always_comb begin
    case (paddr[3:2])
      REG_EWMA_SHIFT: prdata = PDATA_W'(shift_r);
      REG_MIN_LOCAL:  prdata = PDATA_W'(min_local_r);
      REG_MIN_REMOTE: prdata = PDATA_W'(min_remote_r);
      default:        prdata = '0;
    endcase
  end

  assign pready    = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// ===== design/tle_checker.sv =====
`timescale 1ns / 1ps
// Port-level checker of the tier latency estimator and its bind.
// Depends on tle_pkg and tier_latency_estimator.
module tle_checker
  import tle_pkg::*;
(
  input logic      clk,
  input logic      rst_n,
  input logic      in_valid,
  input logic      in_ready,
  input logic      out_valid,
  input logic      out_ready,
  input out_data_t out_data
);

  // Hold a stalled result
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("stalled result changed or dropped");

  // One request in flight: no acceptance right after another
  a_one_inflight: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("request accepted while one is in flight");

  // A priming result carries the 16-bit floors
  a_prime_floor: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.primed_only |->
      out_data.local_latency[63:16] == '0 && out_data.remote_latency[63:16] == '0)
    else $error("priming result wider than its floors");

  // Flag agrees with the two latencies
  a_slower: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.local_slower ==
      (out_data.local_latency > out_data.remote_latency))
    else $error("local_slower disagrees with latencies");

endmodule

bind tier_latency_estimator tle_checker u_tle_checker (
  .clk      (clk),
  .rst_n    (rst_n),
  .in_valid (in_valid),
  .in_ready (in_ready),
  .out_valid(out_valid),
  .out_ready(out_ready),
  .out_data (out_data)
);

// ===== sim/tb_tier_latency_estimator.sv =====
`timescale 1ns / 1ps
// Testbench of tier_latency_estimator: directed and random counter readings through
// the valid/ready channels, with its own latency predictor and APB register writes.
// Depends on tle_pkg and the tier_latency_estimator RTL.
module tb_tier_latency_estimator;
  import tle_pkg::*;

  localparam int FRAC_BITS = FRACTION_BITS_DEF;
  localparam logic [1:0] REG_UNMAPPED = 2'd3;
  // drain time covers the longest request, at shift 15
  localparam int DRAIN_CYCLES = 160;
  localparam int LONG_HOLD = 1500;
  localparam int PHASE_REQUESTS = 170;
  localparam longint TIMEOUT_NS = 64'd10_000_000;

  logic               clk = 1'b0;
  logic               rst_n;
  logic               in_valid;
  logic               in_ready;
  in_data_t           in_data;
  logic               out_valid;
  logic               out_ready;
  out_data_t          out_data;
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [ADDR_W-1:0]  paddr;
  logic [PDATA_W-1:0] pwdata;
  logic [PDATA_W-1:0] prdata;
  logic               pready;

  // predictor state and register copies
  logic [DATA_W-1:0]  last_reading [LANES];
  logic [DATA_W-1:0]  avg_sum [LANES];
  logic               is_primed;
  logic [SHIFT_W-1:0] cfg_shift;
  logic [MIN_W-1:0]   cfg_min_local;
  logic [MIN_W-1:0]   cfg_min_remote;

  // stimulus side
  logic [DATA_W-1:0]  reading_track [LANES];
  out_data_t          expected_latencies [$];
  bit                 offering;
  int                 burst_left;
  bit                 hold_request;

  int requests_sent;
  int results_checked;
  int mismatch_count;
  int settings_applied;

  tier_latency_estimator #(
    .FRACTION_BITS(FRAC_BITS)
  ) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Fold one request into the predictor and return the latency result it causes
  function automatic out_data_t predict_latencies(input in_data_t item);
    out_data_t         res;
    logic [DATA_W-1:0] reading [LANES];
    logic [DATA_W-1:0] floor_val [TIERS];
    logic [DATA_W-1:0] lat [TIERS];
    logic [DATA_W-1:0] sample;
    logic [DATA_W-1:0] keep;
    reading[0] = item.local_occupancy_count;
    reading[1] = item.local_insert_count;
    reading[2] = item.remote_occupancy_count;
    reading[3] = item.remote_insert_count;
    floor_val[0] = DATA_W'(cfg_min_local);
    floor_val[1] = DATA_W'(cfg_min_remote);
    // first request after reset: record the readings, report the minima
    if (!is_primed) begin
      last_reading = reading;
      is_primed = 1'b1;
      res.local_latency = floor_val[0];
      res.remote_latency = floor_val[1];
      res.local_slower = floor_val[0] > floor_val[1];
      res.primed_only = 1'b1;
      return res;
    end
    // wrapping deltas into the moving averages
    keep = (64'd1 << cfg_shift) - 64'd1;
    for (int i = 0; i < LANES; i++) begin
      sample = (reading[i] - last_reading[i]) << FRAC_BITS;
      last_reading[i] = reading[i];
      avg_sum[i] = (sample + keep * avg_sum[i]) >> cfg_shift;
    end
    // occupancy over inserts per tier, with the minimum as floor and fallback
    for (int t = 0; t < TIERS; t++) begin
      lat[t] = (avg_sum[2*t+1] != 0) ? avg_sum[2*t] / avg_sum[2*t+1] : floor_val[t];
      if (lat[t] < floor_val[t]) lat[t] = floor_val[t];
    end
    res.local_latency = lat[0];
    res.remote_latency = lat[1];
    res.local_slower = lat[0] > lat[1];
    res.primed_only = 1'b0;
    return res;
  endfunction

  // Offer one request; hold valid across bursts, drop it for the gaps
  task automatic send_counts(input in_data_t item);
    int gap;
    in_data <= item;
    if (!offering) begin
      in_valid <= 1'b1;
      offering = 1'b1;
    end
    do @(posedge clk); while (!in_ready);
    expected_latencies.push_back(predict_latencies(item));
    requests_sent++;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      burst_left = $urandom_range(0, 24);
      if (gap > 0) begin
        in_valid <= 1'b0;
        offering = 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  task automatic send_readings(input logic [DATA_W-1:0] loc_occ, loc_ins, rem_occ, rem_ins);
    in_data_t item;
    reading_track = '{loc_occ, loc_ins, rem_occ, rem_ins};
    item.local_occupancy_count = loc_occ;
    item.local_insert_count = loc_ins;
    item.remote_occupancy_count = rem_occ;
    item.remote_insert_count = rem_ins;
    send_counts(item);
  endtask

  // Next readings: mostly steady traffic, some huge jumps, some raw noise
  function automatic in_data_t make_counts();
    in_data_t          item;
    logic [DATA_W-1:0] ins_step;
    logic [DATA_W-1:0] lat_guess;
    int                kind;
    kind = $urandom_range(0, 19);
    for (int t = 0; t < TIERS; t++) begin
      if (kind < 16) begin
        ins_step = ($urandom_range(0, 9) == 0) ? 64'd0 : 64'($urandom_range(1, 4000));
        lat_guess = 64'($urandom_range(0, 3000));
        reading_track[2*t+1] += ins_step;
        reading_track[2*t] += ins_step * lat_guess + 64'($urandom_range(0, 255));
      end else if (kind < 18) begin
        reading_track[2*t] += {$urandom(), $urandom()};
        reading_track[2*t+1] += {$urandom(), $urandom()};
      end else begin
        reading_track[2*t] = {$urandom(), $urandom()};
        reading_track[2*t+1] = {$urandom(), $urandom()};
      end
    end
    item.local_occupancy_count = reading_track[0];
    item.local_insert_count = reading_track[1];
    item.remote_occupancy_count = reading_track[2];
    item.remote_insert_count = reading_track[3];
    return item;
  endfunction

  // APB write with junk above the field, then mirror it into the predictor
  task automatic write_register(input logic [1:0] index, input logic [MIN_W-1:0] value);
    logic [PDATA_W-1:0] word;
    case (index)
      REG_EWMA_SHIFT: word = ($urandom() << SHIFT_W) | PDATA_W'(value[SHIFT_W-1:0]);
      REG_MIN_LOCAL,
      REG_MIN_REMOTE: word = ($urandom() << MIN_W) | PDATA_W'(value);
      default:        word = $urandom();
    endcase
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {index, 2'b00};
    pwdata <= word;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    case (index)
      REG_EWMA_SHIFT: cfg_shift = word[SHIFT_W-1:0];
      REG_MIN_LOCAL:  cfg_min_local = word[MIN_W-1:0];
      REG_MIN_REMOTE: cfg_min_remote = word[MIN_W-1:0];
      default: ;
    endcase
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
  endtask

  task automatic apply_setting(input logic [SHIFT_W-1:0] shift,
                               input logic [MIN_W-1:0] min_local, min_remote);
    write_register(REG_EWMA_SHIFT, MIN_W'(shift));
    write_register(REG_MIN_LOCAL, min_local);
    write_register(REG_MIN_REMOTE, min_remote);
    settings_applied++;
  endtask

  // Drop valid, wait for every outstanding result, then let the block go idle
  task automatic settle_idle();
    if (offering) begin
      in_valid <= 1'b0;
      offering = 1'b0;
    end
    while (expected_latencies.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic test_priming_request();
    send_readings(64'd5000, 64'd50, 64'd90000, 64'd100);
    // quotients below both reset minima
    send_readings(64'd5500, 64'd60, 64'd90200, 64'd110);
    settle_idle();
  endtask

  task automatic test_floor_and_fallback();
    // unmapped write must change nothing
    write_register(REG_UNMAPPED, 16'hFFFF);
    apply_setting(4'd0, 16'd0, 16'hFFFF);
    // zero deltas: no inserts on either tier
    send_readings(reading_track[0], reading_track[1], reading_track[2], reading_track[3]);
    send_readings(reading_track[0] + 64'd2800, reading_track[1] + 64'd4,
                  reading_track[2], reading_track[3]);
    settle_idle();
    apply_setting(4'd0, 16'hFFFF, 16'd0);
    send_readings(reading_track[0], reading_track[1],
                  reading_track[2] + 64'd300, reading_track[3] + 64'd10);
    settle_idle();
    // equal fallbacks: local not slower
    apply_setting(4'd0, 16'd500, 16'd500);
    send_readings(reading_track[0], reading_track[1], reading_track[2], reading_track[3]);
    settle_idle();
  endtask

  task automatic test_shift_extremes();
    apply_setting(4'd15, 16'd10, 16'd20);
    repeat (3)
      send_readings(reading_track[0] + 64'd40000, reading_track[1] + 64'd20,
                    reading_track[2] + 64'd90000, reading_track[3] + 64'd30);
    settle_idle();
    apply_setting(4'd8, 16'd0, 16'd0);
    repeat (2)
      send_readings(reading_track[0] + 64'd123456, reading_track[1] + 64'd77,
                    reading_track[2] + 64'd5000, reading_track[3] + 64'd400);
    settle_idle();
    apply_setting(4'd1, 16'd1, 16'd2);
    repeat (2)
      send_readings(reading_track[0] + 64'd900, reading_track[1] + 64'd3,
                    reading_track[2] + 64'd7000, reading_track[3] + 64'd1);
    settle_idle();
  endtask

  task automatic test_counter_wrap();
    apply_setting(4'd0, 16'd0, 16'd0);
    send_readings('1, '1, '1, '1);
    // all-ones to zero is a delta of one
    send_readings('0, '0, '0, '0);
    // delta of 2^63 shifts out entirely
    send_readings({1'b1, 63'd0}, {1'b1, 63'd0}, {1'b1, 63'd0}, {1'b1, 63'd0});
    send_readings(reading_track[0] - 64'd3, reading_track[1] - 64'd1,
                  reading_track[2] - 64'd5, reading_track[3] - 64'd2);
    settle_idle();
    // product and sum in the average wrap at the widest shift
    apply_setting(4'd15, 16'd0, 16'd0);
    repeat (2)
      send_readings(reading_track[0] + {2'b01, 62'd0}, reading_track[1] + 64'h3FFF_FFFF_FFFF,
                    reading_track[2] + {$urandom(), $urandom()},
                    reading_track[3] + {$urandom(), $urandom()});
    settle_idle();
  endtask

  task automatic test_random_traffic();
    for (int phase = 0; phase < 6; phase++) begin
      case (phase)
        0:       apply_setting(4'd1, 16'd0, 16'd0);
        1:       apply_setting(4'd8, 16'hFFFF, 16'hFFFF);
        2:       apply_setting(4'd0, MIN_W'($urandom_range(0, 3000)),
                               MIN_W'($urandom_range(0, 3000)));
        3:       apply_setting(4'd15, 16'd0, 16'hFFFF);
        4:       apply_setting(SHIFT_W'($urandom_range(1, 8)), 16'hFFFF, 16'd0);
        default: apply_setting(SHIFT_W'($urandom_range(1, 8)),
                               MIN_W'($urandom_range(0, 3000)),
                               MIN_W'($urandom_range(0, 3000)));
      endcase
      repeat (PHASE_REQUESTS) send_counts(make_counts());
      settle_idle();
    end
  endtask

  // Hold the output off for a long stretch while requests keep coming
  task automatic test_output_backpressure();
    apply_setting(4'd2, 16'd50, 16'd150);
    hold_request = 1'b1;
    repeat (8) send_counts(make_counts());
    settle_idle();
  endtask

  // Result acceptor: random stall patterns, free-flowing stretches, one long hold
  initial begin
    logic [15:0] stall_pattern;
    logic [3:0]  pattern_bit;
    int          pattern_left;
    pattern_left = 0;
    pattern_bit = '0;
    stall_pattern = '1;
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_request) begin
        out_ready <= 1'b0;
        for (int held = 0; held < LONG_HOLD; held++) @(posedge clk);
        hold_request = 1'b0;
      end else begin
        if (pattern_left == 0) begin
          stall_pattern = ($urandom_range(0, 3) == 0) ? 16'hFFFF : 16'($urandom());
          stall_pattern[4'($urandom_range(0, 15))] = 1'b1;
          pattern_left = $urandom_range(20, 200);
        end
        out_ready <= stall_pattern[pattern_bit];
        pattern_bit++;
        pattern_left--;
      end
    end
  end

  // Compare each accepted result with the oldest prediction
  always @(posedge clk) begin
    out_data_t wanted;
    if (rst_n && out_valid && out_ready) begin
      if (expected_latencies.size() == 0) begin
        $display("%0t: result with no request outstanding: %h", $time, out_data);
        mismatch_count++;
      end else begin
        wanted = expected_latencies.pop_front();
        results_checked++;
        if (out_data.local_latency !== wanted.local_latency) begin
          $display("%0t: local_latency expected %0d got %0d", $time,
                   wanted.local_latency, out_data.local_latency);
          mismatch_count++;
        end
        if (out_data.remote_latency !== wanted.remote_latency) begin
          $display("%0t: remote_latency expected %0d got %0d", $time,
                   wanted.remote_latency, out_data.remote_latency);
          mismatch_count++;
        end
        if (out_data.local_slower !== wanted.local_slower) begin
          $display("%0t: local_slower expected %b got %b", $time,
                   wanted.local_slower, out_data.local_slower);
          mismatch_count++;
        end
        if (out_data.primed_only !== wanted.primed_only) begin
          $display("%0t: primed_only expected %b got %b", $time,
                   wanted.primed_only, out_data.primed_only);
          mismatch_count++;
        end
      end
    end
  end

  initial begin
    #(TIMEOUT_NS);
    $display("tier_latency_estimator test failed");
    $finish;
  end

  initial begin
    int wait_cycles;
    // reset values of the predictor
    cfg_shift = SHIFT_RESET;
    cfg_min_local = MIN_LOCAL_RESET;
    cfg_min_remote = MIN_REMOTE_RESET;
    is_primed = 1'b0;
    for (int i = 0; i < LANES; i++) begin
      last_reading[i] = '0;
      avg_sum[i] = '0;
      reading_track[i] = '0;
    end
    offering = 1'b0;
    burst_left = 0;
    hold_request = 1'b0;
    requests_sent = 0;
    results_checked = 0;
    mismatch_count = 0;
    settings_applied = 0;
    rst_n <= 1'b0;
    in_valid <= 1'b0;
    in_data <= '0;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= '0;
    pwdata <= '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_priming_request();
    test_floor_and_fallback();
    test_shift_extremes();
    test_counter_wrap();
    test_random_traffic();
    test_output_backpressure();

    // wait out the last results, bounded
    for (wait_cycles = 0; expected_latencies.size() != 0 && wait_cycles < 50000;
         wait_cycles++)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (expected_latencies.size() != 0) begin
      $display("%0t: %0d expected results never arrived", $time, expected_latencies.size());
      mismatch_count += expected_latencies.size();
    end
    $display("Checked %0d latency results from %0d requests over %0d register settings",
             results_checked, requests_sent, settings_applied);
    $display("Covered priming, fallback and floor, shift 0 to 15, counter wrap, long output stall");
    if (mismatch_count == 0) begin
      $display("tier_latency_estimator test passed");
    end else begin
      $display("tier_latency_estimator test failed");
    end
    $finish;
  end

endmodule
